### rtl/ktaf_pkg.sv
// ktaf_pkg: shared types, constants and helpers of the tilt-angle kalman filter
// used by ktaf_ctrl, ktaf_datapath, the top level and the checker
package ktaf_pkg;

  localparam int ANG_W     = 32;
  localparam int COV_W     = 48;
  localparam int DT_W      = 24;
  localparam int NOISE_W   = 32;
  localparam int MAG_W     = 48;
  localparam int PROD_W    = 96;
  localparam int MUL_DIGIT = 8;
  localparam int MUL_STEPS = MAG_W / MUL_DIGIT;
  localparam int DIV_ITERS = 47;
  localparam int DIV_W     = 49;
  localparam int CNT_W     = 6;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 2'd2;

  localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST = 32'd16777;
  localparam logic [NOISE_W-1:0] BIAS_NOISE_RST  = 32'd50332;
  localparam logic [NOISE_W-1:0] MEAS_NOISE_RST  = 32'd503316;
  localparam logic signed [COV_W-1:0] COV_ONE    = 48'sh0001_0000_0000;

  typedef enum logic [3:0] {
    ST_ANG_PRED, ST_D11, ST_P00_PRED, ST_P11_PRED, ST_PREP, ST_K0, ST_K1,
    ST_ANG_CORR, ST_BIAS_CORR, ST_K1P00, ST_K1P01, ST_K0P01, ST_K0P00, ST_DONE
  } step_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD_IN, OP_MUL_LOAD, OP_MUL_STEP, OP_ROUND, OP_APPLY,
    OP_PREP, OP_DIV_LOAD, OP_DIV_STEP, OP_DIV_STORE, OP_OUT
  } dp_op_e;

  typedef enum logic [3:0] {
    CS_IDLE, CS_MLOAD, CS_MSTEP, CS_ROUND, CS_APPLY, CS_PREP,
    CS_DLOAD, CS_DSTEP, CS_DSTORE, CS_OUT
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e op;
    step_e  step;
  } dp_cmd_t;

  function automatic step_e next_step(input step_e s);
    step_e n;
    unique case (s)
      ST_ANG_PRED:  n = ST_D11;
      ST_D11:       n = ST_P00_PRED;
      ST_P00_PRED:  n = ST_P11_PRED;
      ST_P11_PRED:  n = ST_PREP;
      ST_PREP:      n = ST_K0;
      ST_K0:        n = ST_K1;
      ST_K1:        n = ST_ANG_CORR;
      ST_ANG_CORR:  n = ST_BIAS_CORR;
      ST_BIAS_CORR: n = ST_K1P00;
      ST_K1P00:     n = ST_K1P01;
      ST_K1P01:     n = ST_K0P01;
      ST_K0P01:     n = ST_K0P00;
      default:      n = ST_DONE;
    endcase
    return n;
  endfunction

  function automatic logic step_is_div(input step_e s);
    return (s == ST_K0) || (s == ST_K1);
  endfunction

  function automatic logic signed [COV_W-1:0] sat_cov(input logic signed [50:0] x);
    logic signed [COV_W-1:0] r;
    if (x > $signed({4'b0000, {47{1'b1}}})) begin
      r = {1'b0, {47{1'b1}}};
    end else if (x < $signed({4'b1111, {47{1'b0}}})) begin
      r = {1'b1, {47{1'b0}}};
    end else begin
      r = x[COV_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [48:0] x);
    logic signed [ANG_W-1:0] r;
    if (x > $signed({18'b0, {31{1'b1}}})) begin
      r = {1'b0, {31{1'b1}}};
    end else if (x < $signed({18'h3ffff, {31{1'b0}}})) begin
      r = {1'b1, {31{1'b0}}};
    end else begin
      r = x[ANG_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/ktaf_ctrl.sv
// ktaf_ctrl: sequencer that walks the filter steps and drives the datapath
// depends on ktaf_pkg
module ktaf_ctrl import ktaf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  step_e       step_q, step_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic        out_valid_q, out_valid_d;
  step_e       nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      step_q      <= ST_ANG_PRED;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o.op    = OP_NONE;
    cmd_o.step  = step_q;
    in_ready_o  = 1'b0;
    nxt         = next_step(step_q);
    unique case (state_q)
      CS_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD_IN;
          step_d   = ST_ANG_PRED;
          state_d  = CS_MLOAD;
        end
      end
      CS_MLOAD: begin
        cmd_o.op = OP_MUL_LOAD;
        cnt_d    = '0;
        state_d  = CS_MSTEP;
      end
      CS_MSTEP: begin
        cmd_o.op = OP_MUL_STEP;
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          state_d = CS_ROUND;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      CS_ROUND: begin
        cmd_o.op = OP_ROUND;
        state_d  = CS_APPLY;
      end
      CS_DLOAD: begin
        cmd_o.op = OP_DIV_LOAD;
        cnt_d    = '0;
        state_d  = CS_DSTEP;
      end
      CS_DSTEP: begin
        cmd_o.op = OP_DIV_STEP;
        if (cnt_q == CNT_W'(DIV_ITERS - 1)) begin
          state_d = CS_DSTORE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      CS_APPLY, CS_PREP, CS_DSTORE: begin
        if (state_q == CS_APPLY) begin
          cmd_o.op = OP_APPLY;
        end else if (state_q == CS_PREP) begin
          cmd_o.op = OP_PREP;
        end else begin
          cmd_o.op = OP_DIV_STORE;
        end
        step_d = nxt;
        if (nxt == ST_DONE) begin
          state_d = CS_OUT;
        end else if (nxt == ST_PREP) begin
          state_d = CS_PREP;
        end else if (step_is_div(nxt)) begin
          state_d = CS_DLOAD;
        end else begin
          state_d = CS_MLOAD;
        end
      end
      CS_OUT: begin
        // hold the finished angle until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_OUT;
          out_valid_d = 1'b1;
          state_d     = CS_IDLE;
        end
      end
      default: state_d = CS_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

### rtl/ktaf_datapath.sv
// ktaf_datapath: filter state, config registers, shared serial multiplier and divider
// depends on ktaf_pkg; driven by ktaf_ctrl
module ktaf_datapath import ktaf_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dp_cmd_t                     cmd_i,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [NOISE_W-1:0]          cfg_wdata_i,
  input  logic [DT_W-1:0]             time_step_i,
  input  logic signed [ANG_W-1:0]     rate_meas_i,
  input  logic signed [ANG_W-1:0]     tilt_meas_i,
  output logic signed [ANG_W-1:0]     angle_estimate_o
);

  localparam logic [1:0] SH_DT    = 2'd0;
  localparam logic [1:0] SH_NOISE = 2'd1;
  localparam logic [1:0] SH_GAIN  = 2'd2;

  logic [NOISE_W-1:0] apn_q, bpn_q, mn_q;
  logic signed [ANG_W-1:0] ang_q, bias_q;
  logic signed [COV_W-1:0] p00_q, p01_q, p10_q, p11_q;
  logic [DT_W-1:0] dt_q;
  logic signed [ANG_W-1:0] rate_q, acc_q, est_q;
  logic signed [COV_W-1:0] inner_q, t_q, k0_q, k1_q;
  logic signed [32:0] y_q;
  logic signed [DIV_W-1:0] s_q;
  logic s_pos_q;

  logic [MAG_W-1:0] ma_q, mb_q;
  logic neg_q;
  logic [1:0] sh_q;
  logic [PROD_W-1:0] prod_q;

  logic [DIV_W-1:0] dsor_q;
  logic [DIV_W:0] rem_q;
  logic [DIV_ITERS-1:0] nbits_q, quo_q;
  logic dsat_q, nneg_q;

  function automatic logic [MAG_W-1:0] mag49(input logic signed [48:0] x);
    logic [48:0] u;
    u = x[48] ? 49'(-x) : 49'(x);
    return u[MAG_W-1:0];
  endfunction

  // operand selection for the current step
  logic signed [48:0] opa, opb;
  logic [1:0] sh_sel;
  logic signed [32:0] rate_diff;

  always_comb begin
    rate_diff = {rate_q[31], rate_q} - {bias_q[31], bias_q};
    opa    = '0;
    opb    = '0;
    sh_sel = SH_GAIN;
    case (cmd_i.step)
      ST_ANG_PRED: begin
        opa = {25'b0, dt_q}; opb = {{16{rate_diff[32]}}, rate_diff}; sh_sel = SH_DT;
      end
      ST_D11: begin
        opa = {25'b0, dt_q}; opb = {p11_q[47], p11_q}; sh_sel = SH_DT;
      end
      ST_P00_PRED: begin
        opa = {25'b0, dt_q}; opb = {inner_q[47], inner_q}; sh_sel = SH_DT;
      end
      ST_P11_PRED: begin
        opa = {17'b0, bpn_q}; opb = {25'b0, dt_q}; sh_sel = SH_NOISE;
      end
      ST_ANG_CORR: begin
        opa = {k0_q[47], k0_q}; opb = {{16{y_q[32]}}, y_q};
      end
      ST_BIAS_CORR: begin
        opa = {k1_q[47], k1_q}; opb = {{16{y_q[32]}}, y_q};
      end
      ST_K1P00: begin opa = {k1_q[47], k1_q}; opb = {p00_q[47], p00_q}; end
      ST_K1P01: begin opa = {k1_q[47], k1_q}; opb = {p01_q[47], p01_q}; end
      ST_K0P01: begin opa = {k0_q[47], k0_q}; opb = {p01_q[47], p01_q}; end
      ST_K0P00: begin opa = {k0_q[47], k0_q}; opb = {p00_q[47], p00_q}; end
      default: begin
        opa = '0; opb = '0;
      end
    endcase
  end

  // one 48x8 digit per cycle, partial product enters at the top
  logic [55:0] pp, psum;
  assign pp   = ma_q * mb_q[MUL_DIGIT-1:0];
  assign psum = {8'b0, prod_q[PROD_W-1:MAG_W]} + pp;

  // round half away from zero on the magnitude, then clamp
  logic [96:0] rsum, rq, lim;
  logic [MAG_W-1:0] rmag;
  always_comb begin
    rsum = {1'b0, prod_q};
    rq   = '0;
    case (sh_q)
      SH_DT: begin
        rsum = {1'b0, prod_q} + (97'(1) << 23);
        rq   = rsum >> 24;
      end
      SH_NOISE: begin
        rsum = {1'b0, prod_q} + (97'(1) << 15);
        rq   = rsum >> 16;
      end
      default: begin
        rsum = {1'b0, prod_q} + (97'(1) << 31);
        rq   = rsum >> 32;
      end
    endcase
    lim  = neg_q ? {49'b0, 1'b1, 47'b0} : {50'b0, {47{1'b1}}};
    rmag = (rq > lim) ? lim[MAG_W-1:0] : rq[MAG_W-1:0];
  end

  // exact sums before saturation
  logic signed [48:0] ang_sum, bias_sum;
  logic signed [50:0] inner_sum;
  logic signed [48:0] p00_add, p11_add, p00_sub, p01_sub, p10_sub, p11_sub;
  always_comb begin
    ang_sum   = {{17{ang_q[31]}}, ang_q} + {t_q[47], t_q};
    bias_sum  = {{17{bias_q[31]}}, bias_q} + {t_q[47], t_q};
    inner_sum = {{3{t_q[47]}}, t_q} - {{3{p01_q[47]}}, p01_q} - {{3{p10_q[47]}}, p10_q}
                + {11'b0, apn_q, 8'b0};
    p00_add   = {p00_q[47], p00_q} + {t_q[47], t_q};
    p11_add   = {p11_q[47], p11_q} + {t_q[47], t_q};
    p00_sub   = {p00_q[47], p00_q} - {t_q[47], t_q};
    p01_sub   = {p01_q[47], p01_q} - {t_q[47], t_q};
    p10_sub   = {p10_q[47], p10_q} - {t_q[47], t_q};
    p11_sub   = {p11_q[47], p11_q} - {t_q[47], t_q};
  end

  // divider helpers
  logic signed [COV_W-1:0] num;
  logic [MAG_W-1:0] nmag;
  logic [DIV_W:0] rt;
  logic ge;
  logic [COV_W-1:0] dres;
  logic signed [COV_W-1:0] kval;
  logic signed [DIV_W-1:0] s_new;
  always_comb begin
    num  = (cmd_i.step == ST_K0) ? p00_q : p10_q;
    nmag = mag49({num[47], num});
    rt   = {rem_q[DIV_W-1:0], nbits_q[DIV_ITERS-1]};
    ge   = rt >= {1'b0, dsor_q};
    dres = dsat_q ? (nneg_q ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}}) : {1'b0, quo_q};
    if (!s_pos_q) begin
      kval = '0;
    end else if (nneg_q) begin
      kval = -$signed(dres);
    end else begin
      kval = $signed(dres);
    end
    s_new = {p00_q[47], p00_q} + {9'b0, mn_q, 8'b0};
  end

  // configuration and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apn_q  <= ANGLE_NOISE_RST;
      bpn_q  <= BIAS_NOISE_RST;
      mn_q   <= MEAS_NOISE_RST;
      ang_q  <= '0;
      bias_q <= '0;
      p00_q  <= COV_ONE;
      p01_q  <= '0;
      p10_q  <= '0;
      p11_q  <= COV_ONE;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ANGLE_NOISE: apn_q <= cfg_wdata_i;
          CFG_BIAS_NOISE:  bpn_q <= cfg_wdata_i;
          CFG_MEAS_NOISE:  mn_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_APPLY) begin
        case (cmd_i.step)
          ST_ANG_PRED, ST_ANG_CORR: ang_q <= sat_ang(ang_sum);
          ST_BIAS_CORR: bias_q <= sat_ang(bias_sum);
          ST_D11: begin
            p01_q <= sat_cov({{2{p01_sub[48]}}, p01_sub});
            p10_q <= sat_cov({{2{p10_sub[48]}}, p10_sub});
          end
          ST_P00_PRED: p00_q <= sat_cov({{2{p00_add[48]}}, p00_add});
          ST_P11_PRED: p11_q <= sat_cov({{2{p11_add[48]}}, p11_add});
          ST_K1P00:    p10_q <= sat_cov({{2{p10_sub[48]}}, p10_sub});
          ST_K1P01:    p11_q <= sat_cov({{2{p11_sub[48]}}, p11_sub});
          ST_K0P01:    p01_q <= sat_cov({{2{p01_sub[48]}}, p01_sub});
          ST_K0P00:    p00_q <= sat_cov({{2{p00_sub[48]}}, p00_sub});
          default: ;
        endcase
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD_IN: begin
        dt_q   <= time_step_i;
        rate_q <= rate_meas_i;
        acc_q  <= tilt_meas_i;
      end
      OP_MUL_LOAD: begin
        ma_q   <= mag49(opa);
        mb_q   <= mag49(opb);
        neg_q  <= opa[48] ^ opb[48];
        sh_q   <= sh_sel;
        prod_q <= '0;
      end
      OP_MUL_STEP: begin
        prod_q <= {psum, prod_q[MAG_W-1:MUL_DIGIT]};
        mb_q   <= mb_q >> MUL_DIGIT;
      end
      OP_ROUND: t_q <= neg_q ? -$signed(rmag) : $signed(rmag);
      OP_APPLY: begin
        if (cmd_i.step == ST_D11) begin
          inner_q <= sat_cov(inner_sum);
        end
      end
      OP_PREP: begin
        y_q     <= {acc_q[31], acc_q} - {ang_q[31], ang_q};
        s_q     <= s_new;
        s_pos_q <= !s_new[48] && (s_new != '0);
      end
      OP_DIV_LOAD: begin
        dsor_q  <= s_q;
        // quotient of at least 2^15 saturates the gain
        dsat_q  <= {16'b0, nmag} >= {s_q, 15'b0};
        rem_q   <= {17'b0, nmag[MAG_W-1:15]};
        nbits_q <= {nmag[14:0], 32'b0};
        quo_q   <= '0;
        nneg_q  <= num[47];
      end
      OP_DIV_STEP: begin
        rem_q   <= ge ? (rt - {1'b0, dsor_q}) : rt;
        quo_q   <= {quo_q[DIV_ITERS-2:0], ge};
        nbits_q <= nbits_q << 1;
      end
      OP_DIV_STORE: begin
        if (cmd_i.step == ST_K0) begin
          k0_q <= kval;
        end else begin
          k1_q <= kval;
        end
      end
      OP_OUT: est_q <= ang_q;
      default: ;
    endcase
  end

  assign angle_estimate_o = est_q;

endmodule

### rtl/kalman_tilt_angle_filter_core.sv
// kalman_tilt_angle_filter_core: two-state kalman tilt filter, top level
// depends on ktaf_pkg, ktaf_ctrl and ktaf_datapath
//
// usage
//   input channel carries time_step, rate_meas and tilt_meas with in_valid_i and
//   in_ready_o; a request is taken when both are high. the output channel returns one
//   angle_estimate per input request with out_valid_o and out_ready_i. the user
//   must write the noise registers through cfg_we_i, cfg_index_i and cfg_wdata_i only
//   while the filter is idle; the block does not enforce it. index 3 is ignored.
// timing
//   one request at a time: in_ready_o rises in the same cycle as out_valid_o. the
//   time from acceptance to out_valid_o is set by ten passes through the shared
//   48x8-per-cycle multiplier, two restoring divisions for the gains (load, 47 steps,
//   store), the innovation step, the load of the output register and any wait for it.
// reset
//   rst_ni clears angle and bias, sets both variances to one and loads the default
//   noise settings; no result is pending.
// stalls
//   a result waits in the output register; the next request may be taken and
//   worked on, and it holds in its final step until the register is free.
module kalman_tilt_angle_filter_core import ktaf_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [DT_W-1:0]         time_step_i,
  input  logic signed [ANG_W-1:0] rate_meas_i,
  input  logic signed [ANG_W-1:0] tilt_meas_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [ANG_W-1:0] angle_estimate_o,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [NOISE_W-1:0]      cfg_wdata_i
);

  dp_cmd_t cmd;

  ktaf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  ktaf_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .time_step_i      (time_step_i),
    .rate_meas_i      (rate_meas_i),
    .tilt_meas_i      (tilt_meas_i),
    .angle_estimate_o (angle_estimate_o)
  );

endmodule

### rtl/ktaf_checker.sv
// ktaf_checker: port-level checks of the tilt filter, bound to the top level
// depends on ktaf_pkg and kalman_tilt_angle_filter_core
module ktaf_checker import ktaf_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic [DT_W-1:0]         time_step_i,
  input logic signed [ANG_W-1:0] rate_meas_i,
  input logic signed [ANG_W-1:0] tilt_meas_i,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic signed [ANG_W-1:0] angle_estimate_o,
  input logic                    cfg_we_i,
  input logic [CFG_IDX_W-1:0]    cfg_index_i,
  input logic [NOISE_W-1:0]      cfg_wdata_i
);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(angle_estimate_o))
    else $error("result dropped or changed while stalled");

  // one request in flight: ready drops after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request taken while busy");

  // the filter does not finish a request early
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |-> ##20 !in_ready_o)
    else $error("request finished too early");

  // a new result only appears at the end of a busy period
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result without a request in flight");

endmodule

bind kalman_tilt_angle_filter_core ktaf_checker u_ktaf_checker (.*);
